/* rtl/core/mwpo_pkg.sv */
package mwpo_pkg;

    // wave_select codes
    localparam logic [2:0] WAVE_SINE     = 3'd0;
    localparam logic [2:0] WAVE_SAW      = 3'd1;
    localparam logic [2:0] WAVE_SQUARE   = 3'd2;
    localparam logic [2:0] WAVE_TRIANGLE = 3'd3;
    localparam logic [2:0] WAVE_PWM      = 3'd4;
    localparam logic [2:0] WAVE_NOISE    = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_WAVE_SELECT = 2'd0;
    localparam logic [1:0] CFG_STEP_SCALE  = 2'd1;
    localparam logic [1:0] CFG_NOISE_SEED  = 2'd2;

    // noise hash constants
    localparam logic [31:0] NOISE_INC  = 32'hE120_FC15;
    localparam logic [31:0] NOISE_MUL1 = 32'h4A39_B70D;
    localparam logic [31:0] NOISE_MUL2 = 32'h12FA_D5C9;

    // odd sine polynomial, Q30; Horner order A9, then A7, A5, A3, A1
    localparam logic [31:0] SIN_A9 = 32'd172272;
    localparam logic [31:0] SIN_COEF [4] = '{32'd5026995, 32'd85569306,
                                             32'd693598668, 32'd1686629713};

    // multiplier last digit indexes (radix 4)
    localparam logic [3:0] MUL_FULL_LAST = 4'd15;
    localparam logic [3:0] MUL_HALF_LAST = 4'd7;

    typedef struct packed {
        logic        start;
        logic        half;   // multiplier operand a fits in 16 bits
        logic [31:0] a;
        logic [31:0] b;
    } mul_cmd_t;

    typedef struct packed {
        logic        neg;
        logic [16:0] mag;
    } wave_t;

    typedef struct packed {
        logic        neg;    // lower half of the sine cycle
        logic [30:0] u;      // folded quarter-wave argument, Q30
    } sine_arg_t;

endpackage

/* rtl/core/mwpo_serial_mul.sv */
module mwpo_serial_mul
    import mwpo_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  mul_cmd_t    cmd,
    output logic        done,
    output logic [63:0] prod
);

    logic [31:0] hi_reg;
    logic [31:0] lo_reg;
    logic [31:0] b_reg;
    logic [33:0] b3_reg;
    logic        half_reg;
    logic [3:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [33:0] addend;
    logic [33:0] sum;

    always_comb
    begin
        unique case (lo_reg[1:0])
            2'd0: addend = 34'd0;
            2'd1: addend = {2'b00, b_reg};
            2'd2: addend = {1'b0, b_reg, 1'b0};
            2'd3: addend = b3_reg;
            default: addend = 34'd0;
        endcase
    end

    // hi stays below 2^32 after each shift, so the sum fits in 34 bits
    assign sum = {2'b00, hi_reg} + addend;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 4'd0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 4'd0);
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= cmd.half ? MUL_HALF_LAST : MUL_FULL_LAST;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 4'd1;
                if (cnt_reg == 4'd0)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            hi_reg   <= 32'd0;
            lo_reg   <= cmd.a;
            b_reg    <= cmd.b;
            b3_reg   <= {2'b00, cmd.b} + {1'b0, cmd.b, 1'b0};
            half_reg <= cmd.half;
        end
        else if (busy_reg)
        begin
            hi_reg <= sum[33:2];
            lo_reg <= {sum[1:0], lo_reg[31:2]};
        end
    end

    assign done = done_reg;
    assign prod = half_reg ? {16'd0, hi_reg, lo_reg[31:16]} : {hi_reg, lo_reg};

    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> !busy_reg)
        else $error("multiplier restarted while busy");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> busy_reg)
        else $error("multiplier did not start");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("done raised while still shifting");

endmodule

/* rtl/core/mwpo_shaper.sv */
module mwpo_shaper
    import mwpo_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 1024
)
(
    input  logic [2:0]  wave_sel,
    input  logic [31:0] phase,
    input  logic [15:0] pulse_width,
    output wave_t       direct,
    output sine_arg_t   sine_arg
);

    // table depth is a power of two
    localparam int IDX_BITS = $clog2(SINE_TABLE_DEPTH);
    localparam int PAD_BITS = 32 - IDX_BITS;

    logic [IDX_BITS-1:0] idx;
    logic [29:0]         u_raw;
    logic [31:0]         pwm_thr;

    // sine: low 31 phase bits give two table cycles per wrap
    assign idx   = phase[30 -: IDX_BITS];
    assign u_raw = {idx[IDX_BITS-3:0], {PAD_BITS{1'b0}}};

    assign sine_arg.neg = idx[IDX_BITS-1];
    assign sine_arg.u   = idx[IDX_BITS-2] ? (31'h4000_0000 - {1'b0, u_raw})
                                          : {1'b0, u_raw};

    assign pwm_thr = {~pulse_width[15], pulse_width[14:0], 16'd0};

    always_comb
    begin
        unique case (wave_sel)
            WAVE_SAW:
            begin
                direct.neg = ~phase[31];
                direct.mag = phase[31] ? {1'b0, phase[30:15]}
                                       : (17'h1_0000 - {1'b0, phase[30:15]});
            end
            WAVE_SQUARE:
            begin
                direct.neg = ~phase[31];
                direct.mag = 17'd32768;
            end
            WAVE_TRIANGLE:
            begin
                direct.neg = 1'b0;
                direct.mag = phase[31] ? (17'd16384 - {3'b000, phase[30:17]})
                                       : {3'b000, phase[30:17]};
            end
            WAVE_PWM:
            begin
                direct.neg = phase < pwm_thr;
                direct.mag = 17'd32768;
            end
            default:
            begin
                direct.neg = 1'b0;
                direct.mag = 17'd0;
            end
        endcase
    end

endmodule

/* rtl/core/multi_waveform_phase_oscillator_unit.sv */
// Channel   Dir  Handshake                       Payload
// s_axis    in   s_axis_tvalid / s_axis_tready   frequency, lfo, amplitude, pulse_width
// m_axis    out  m_axis_tvalid / m_axis_tready   sample
// cfg       in   cfg_valid / cfg_ready           cfg_addr, cfg_data
//
// One tick goes through a single radix-4 serial multiplier, in half mode for
// 16-bit multiplies. Sine takes nine multiplies, noise five, the other
// waveforms three.
// The result register frees the input side: a new tick is taken while a sample
// still waits on m_axis; the tick stalls only in ST_RND if that sample still waits.
// Reset clears phase, noise state, configuration and control registers;
// cfg_ready is always high.
module multi_waveform_phase_oscillator_unit
    import mwpo_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH     = 1024,
    parameter int SAMPLE_FRACTION_BITS = 15
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // frequency, lfo, amplitude, pulse_width
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // sample, zero pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_data
);

    localparam int OUT_SHIFT = 30 - SAMPLE_FRACTION_BITS;
    localparam logic [34:0] RND_HALF = 35'd1 << (OUT_SHIFT - 1);

    typedef enum logic [12:0] {
        ST_IDLE     = 13'b0_0000_0000_0001,
        ST_STEP1    = 13'b0_0000_0000_0010,
        ST_STEP2    = 13'b0_0000_0000_0100,
        ST_SHAPE    = 13'b0_0000_0000_1000,
        ST_SIN_U2   = 13'b0_0000_0001_0000,
        ST_SIN_A9   = 13'b0_0000_0010_0000,
        ST_SIN_POLY = 13'b0_0000_0100_0000,
        ST_SIN_S    = 13'b0_0000_1000_0000,
        ST_NZ1      = 13'b0_0001_0000_0000,
        ST_NZ2      = 13'b0_0010_0000_0000,
        ST_AMP_LD   = 13'b0_0100_0000_0000,
        ST_AMP      = 13'b0_1000_0000_0000,
        ST_RND      = 13'b1_0000_0000_0000
    } state_t;

    state_t      state_reg, state_next;
    logic [2:0]  wave_sel_reg, wave_sel_next;
    logic [31:0] scale_reg, scale_next;
    logic [31:0] ns_reg, ns_next;
    logic [31:0] phase_reg, phase_next;
    logic [31:0] acc_reg, acc_next;
    logic [15:0] freq_reg, freq_next;
    logic [15:0] lfo_reg, lfo_next;
    logic [15:0] amp_reg, amp_next;
    logic [15:0] pw_reg, pw_next;
    logic [30:0] u_reg, u_next;
    logic [31:0] u2_reg, u2_next;
    logic        sneg_reg, sneg_next;
    logic [1:0]  poly_cnt_reg, poly_cnt_next;
    logic        w_neg_reg, w_neg_next;
    logic [16:0] w_mag_reg, w_mag_next;
    logic [33:0] prod_reg, prod_next;
    logic [16:0] sample_reg, sample_next;
    logic        out_valid_reg, out_valid_next;

    mul_cmd_t    mul_cmd;
    logic        mul_done;
    logic [63:0] mul_prod;
    logic [31:0] mul_q30;
    logic [31:0] hash;
    logic [31:0] sine_sum;
    logic [16:0] sine_v;
    logic [1:0]  coef_idx;
    logic        out_free;
    wave_t       direct;
    sine_arg_t   sine_arg;

    logic signed [34:0] rnd_sum;
    logic signed [34:0] rnd_shift;
    logic               sat_hi;
    logic               sat_lo;
    logic [16:0]        rnd_sample;

    mwpo_serial_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mul_cmd),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    mwpo_shaper #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_shaper (
        .wave_sel    (wave_sel_reg),
        .phase       (phase_reg),
        .pulse_width (pw_reg),
        .direct      (direct),
        .sine_arg    (sine_arg)
    );

    assign mul_q30  = mul_prod[61:30];
    assign hash     = mul_prod[63:32] ^ mul_prod[31:0];
    assign sine_sum = mul_q30 + 32'd16384;
    assign sine_v   = (sine_sum[31:15] > 17'd32768) ? 17'd32768 : sine_sum[31:15];
    assign coef_idx = poly_cnt_reg + 2'd1;
    assign out_free = !out_valid_reg || m_axis_tready;

    // round half up, then clamp to 17 bits
    assign rnd_sum    = {prod_reg[33], prod_reg} + RND_HALF;
    assign rnd_shift  = rnd_sum >>> OUT_SHIFT;
    assign sat_hi     = !rnd_shift[34] && (rnd_shift[33:16] != 18'd0);
    assign sat_lo     = rnd_shift[34] && (rnd_shift[33:16] != 18'h3_FFFF);
    assign rnd_sample = sat_hi ? 17'h0_FFFF : (sat_lo ? 17'h1_0000 : rnd_shift[16:0]);

    always_comb
    begin
        state_next     = state_reg;
        wave_sel_next  = wave_sel_reg;
        scale_next     = scale_reg;
        ns_next        = ns_reg;
        phase_next     = phase_reg;
        acc_next       = acc_reg;
        freq_next      = freq_reg;
        lfo_next       = lfo_reg;
        amp_next       = amp_reg;
        pw_next        = pw_reg;
        u_next         = u_reg;
        u2_next        = u2_reg;
        sneg_next      = sneg_reg;
        poly_cnt_next  = poly_cnt_reg;
        w_neg_next     = w_neg_reg;
        w_mag_next     = w_mag_reg;
        prod_next      = prod_reg;
        sample_next    = sample_reg;
        out_valid_next = out_valid_reg;
        mul_cmd        = '0;

        if (m_axis_tvalid && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    freq_next    = s_axis_tdata[15:0];
                    lfo_next     = s_axis_tdata[31:16];
                    amp_next     = s_axis_tdata[47:32];
                    pw_next      = s_axis_tdata[63:48];
                    mul_cmd.start = 1'b1;
                    mul_cmd.half  = 1'b1;
                    mul_cmd.a     = {16'd0, s_axis_tdata[15:0]};
                    mul_cmd.b     = scale_reg;
                    state_next    = ST_STEP1;
                end
            end
            ST_STEP1:
            begin
                if (mul_done)
                begin
                    acc_next      = phase_reg + mul_prod[47:16];
                    mul_cmd.start = 1'b1;
                    mul_cmd.half  = 1'b1;
                    mul_cmd.a     = {16'd0, freq_reg};
                    mul_cmd.b     = {{16{lfo_reg[15]}}, lfo_reg};
                    state_next    = ST_STEP2;
                end
            end
            ST_STEP2:
            begin
                if (mul_done)
                begin
                    phase_next = acc_reg + mul_prod[31:0];
                    state_next = ST_SHAPE;
                end
            end
            ST_SHAPE:
            begin
                unique case (wave_sel_reg)
                    WAVE_SINE:
                    begin
                        u_next        = sine_arg.u;
                        sneg_next     = sine_arg.neg;
                        mul_cmd.start = 1'b1;
                        mul_cmd.a     = {1'b0, sine_arg.u};
                        mul_cmd.b     = {1'b0, sine_arg.u};
                        state_next    = ST_SIN_U2;
                    end
                    WAVE_NOISE:
                    begin
                        ns_next       = ns_reg + NOISE_INC;
                        mul_cmd.start = 1'b1;
                        mul_cmd.a     = ns_reg + NOISE_INC;
                        mul_cmd.b     = NOISE_MUL1;
                        state_next    = ST_NZ1;
                    end
                    default:
                    begin
                        w_neg_next = direct.neg;
                        w_mag_next = direct.mag;
                        state_next = ST_AMP_LD;
                    end
                endcase
            end
            ST_SIN_U2:
            begin
                if (mul_done)
                begin
                    u2_next       = mul_q30;
                    mul_cmd.start = 1'b1;
                    mul_cmd.a     = mul_q30;
                    mul_cmd.b     = SIN_A9;
                    state_next    = ST_SIN_A9;
                end
            end
            ST_SIN_A9:
            begin
                if (mul_done)
                begin
                    poly_cnt_next = 2'd0;
                    mul_cmd.start = 1'b1;
                    mul_cmd.a     = SIN_COEF[0] - mul_q30;
                    mul_cmd.b     = u2_reg;
                    state_next    = ST_SIN_POLY;
                end
            end
            ST_SIN_POLY:
            begin
                if (mul_done)
                begin
                    // last Horner step multiplies by u instead of u^2
                    poly_cnt_next = poly_cnt_reg + 2'd1;
                    mul_cmd.start = 1'b1;
                    mul_cmd.a     = SIN_COEF[coef_idx] - mul_q30;
                    mul_cmd.b     = (poly_cnt_reg == 2'd2) ? {1'b0, u_reg} : u2_reg;
                    if (poly_cnt_reg == 2'd2)
                    begin
                        state_next = ST_SIN_S;
                    end
                end
            end
            ST_SIN_S:
            begin
                if (mul_done)
                begin
                    w_neg_next = sneg_reg;
                    w_mag_next = sine_v;
                    state_next = ST_AMP_LD;
                end
            end
            ST_NZ1:
            begin
                if (mul_done)
                begin
                    mul_cmd.start = 1'b1;
                    mul_cmd.a     = hash;
                    mul_cmd.b     = NOISE_MUL2;
                    state_next    = ST_NZ2;
                end
            end
            ST_NZ2:
            begin
                if (mul_done)
                begin
                    // (hash >> 16) - 32768 as sign and magnitude
                    w_neg_next = ~hash[31];
                    w_mag_next = hash[31] ? {2'b00, hash[30:16]}
                                          : (17'd32768 - {2'b00, hash[30:16]});
                    state_next = ST_AMP_LD;
                end
            end
            ST_AMP_LD:
            begin
                mul_cmd.start = 1'b1;
                mul_cmd.half  = 1'b1;
                mul_cmd.a     = {16'd0, amp_reg};
                mul_cmd.b     = {15'd0, w_mag_reg};
                state_next    = ST_AMP;
            end
            ST_AMP:
            begin
                if (mul_done)
                begin
                    prod_next  = w_neg_reg ? (34'd0 - {1'b0, mul_prod[32:0]})
                                           : {1'b0, mul_prod[32:0]};
                    state_next = ST_RND;
                end
            end
            ST_RND:
            begin
                if (out_free)
                begin
                    sample_next    = rnd_sample;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_valid)
        begin
            unique case (cfg_addr)
                CFG_WAVE_SELECT: wave_sel_next = cfg_data[2:0];
                CFG_STEP_SCALE:  scale_next    = cfg_data;
                CFG_NOISE_SEED:  ns_next       = cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wave_sel_reg  <= WAVE_SINE;
            scale_reg     <= 32'd0;
            ns_reg        <= 32'd0;
            phase_reg     <= 32'd0;
            poly_cnt_reg  <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wave_sel_reg  <= wave_sel_next;
            scale_reg     <= scale_next;
            ns_reg        <= ns_next;
            phase_reg     <= phase_next;
            poly_cnt_reg  <= poly_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        freq_reg   <= freq_next;
        lfo_reg    <= lfo_next;
        amp_reg    <= amp_next;
        pw_reg     <= pw_next;
        u_reg      <= u_next;
        u2_reg     <= u2_next;
        sneg_reg   <= sneg_next;
        w_neg_reg  <= w_neg_next;
        w_mag_reg  <= w_mag_next;
        prod_reg   <= prod_next;
        sample_reg <= sample_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, sample_reg};
    assign cfg_ready     = 1'b1;

    a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_STEP2) |=> $stable(phase_reg))
        else $error("phase changed outside the accumulate step");

    a_noise_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!cfg_valid && (state_reg != ST_SHAPE)) |=> $stable(ns_reg))
        else $error("noise state changed without seed write or noise tick");

    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg == ST_STEP1))
        else $error("accepted transaction did not start the phase step");

endmodule
